// ===== sv/rsnh_pkg.sv =====
package rsnh_pkg;

    localparam int COORD_BITS = 16;
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int ACC_BITS   = (2 * COORD_BITS + 3 > 64) ? 64 : 2 * COORD_BITS + 3;
    localparam int FRAC_BITS  = 16;
    localparam int BEST_BITS  = FRAC_BITS + 1;
    localparam int PROD_BITS  = DIFF_BITS + FRAC_BITS + 1;
    localparam int STEP_BITS  = $clog2(DIFF_BITS > FRAC_BITS ? DIFF_BITS : FRAC_BITS);

    localparam logic [BEST_BITS-1:0] FRAC_ONE    = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [FRAC_BITS-1:0] CRASH_RESET = 16'd3277;

    localparam logic FUNC_RAY  = 1'b0;
    localparam logic FUNC_WALL = 1'b1;

    typedef struct packed {
        logic                         func;
        logic signed [COORD_BITS-1:0] point_a_x;
        logic signed [COORD_BITS-1:0] point_a_y;
        logic signed [COORD_BITS-1:0] point_b_x;
        logic signed [COORD_BITS-1:0] point_b_y;
        logic                         last_wall;
    } item_t;

    typedef struct packed {
        logic                         hit;
        logic signed [COORD_BITS-1:0] hit_x;
        logic signed [COORD_BITS-1:0] hit_y;
        logic [BEST_BITS-1:0]         nearest_fraction;
        logic                         crash;
        logic                         alive;
    } result_t;

endpackage

// ===== sv/rsnh_serial_div.sv =====
module rsnh_serial_div #(
    parameter int WIDTH    = 35,
    parameter int QUO_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [WIDTH-1:0]    numer,
    input  logic [WIDTH-1:0]    denom,
    output logic                done,
    output logic [QUO_BITS-1:0] quotient
);

    localparam int CNT_BITS = $clog2(QUO_BITS);

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic [WIDTH-1:0]    rem_reg;
    logic [WIDTH-1:0]    den_reg;
    logic [QUO_BITS-1:0] quo_reg;

    logic [WIDTH-1:0]    rem_shift;
    logic                ge;
    logic [WIDTH-1:0]    rem_step;
    logic                last_step;

    // restoring division, one quotient bit per cycle
    assign rem_shift = {rem_reg[WIDTH-2:0], 1'b0};
    assign ge        = rem_shift >= den_reg;
    assign rem_step  = ge ? rem_shift - den_reg : rem_shift;
    assign last_step = cnt_reg == CNT_BITS'(QUO_BITS - 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && last_step;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_BITS'(1);
                if (last_step)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= numer;
            den_reg <= denom;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_step;
            quo_reg <= {quo_reg[QUO_BITS-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== sv/ray_segment_nearest_hit_core.sv =====
// A ray is loaded in the idle state. Each wall runs the 17-step shift-add multiply and
// a bounds check; a wall that is not skipped there (parallel or outside) goes on to the
// 16-step restoring divider. A last wall adds the 16-step clip multiply on a hit; the
// result then sits in an output register. Reset is asynchronous, active
// low: ray cleared to zero, nearest fraction to one, alive set, threshold to 0.05.
module ray_segment_nearest_hit_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_ready,
    input  rsnh_pkg::item_t                   item,
    output logic                              result_valid,
    input  logic                              result_ready,
    output rsnh_pkg::result_t                 result,
    input  logic                              threshold_we,
    input  logic [rsnh_pkg::FRAC_BITS-1:0]    threshold_data
);

    localparam int CB   = rsnh_pkg::COORD_BITS;
    localparam int DB   = rsnh_pkg::DIFF_BITS;
    localparam int AB   = rsnh_pkg::ACC_BITS;
    localparam int FB   = rsnh_pkg::FRAC_BITS;
    localparam int BB   = rsnh_pkg::BEST_BITS;
    localparam int PB   = rsnh_pkg::PROD_BITS;
    localparam int SB   = rsnh_pkg::STEP_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_CHECK,
        S_DIV,
        S_FINISH,
        S_SCALE,
        S_EMIT
    } state_t;

    state_t                state_reg, state_next;
    logic [SB-1:0]         step_reg;
    logic [BB-1:0]         best_reg, best_next;
    logic                  alive_reg;
    logic [FB-1:0]         threshold_reg;
    logic signed [CB-1:0]  ray_ox_reg, ray_oy_reg, ray_ex_reg, ray_ey_reg;
    logic                  last_reg;
    logic                  result_valid_reg;
    rsnh_pkg::result_t     result_reg;

    logic [DB-1:0]         sr_dx_reg, sr_dy_reg, sr_wx_reg, sr_wy_reg;
    logic signed [AB-1:0]  mc_wy_reg, mc_wx_reg, mc_py_reg, mc_px_reg;
    logic signed [AB-1:0]  den_reg, n1_reg, n2_reg;
    logic [FB-1:0]         sr_frac_reg;
    logic signed [PB-1:0]  mx_reg, my_reg, px_reg, py_reg;

    logic signed [CB-1:0]  ax, ay, bx, by;
    logic signed [DB-1:0]  dx_d, dy_d, wx_d, wy_d, px_d, py_d;
    logic                  sign_step;
    logic signed [AB-1:0]  den_add, n1_add, n2_add;
    logic                  den_neg;
    logic [AB-1:0]         den_a, n1_a, n2_a;
    logic                  wall_ok;
    logic                  div_start;
    logic                  div_done;
    logic [FB-1:0]         div_quo;
    logic                  out_free;
    logic                  hit;
    logic                  crash;
    logic signed [PB-1:0]  sum_x, sum_y;

    function automatic logic signed [AB-1:0] pp(
        input logic                 b,
        input logic                 neg,
        input logic signed [AB-1:0] m
    );
        return b ? (neg ? -m : m) : '0;
    endfunction

    assign ax = item.point_a_x;
    assign ay = item.point_a_y;
    assign bx = item.point_b_x;
    assign by = item.point_b_y;

    assign dx_d = DB'(ray_ex_reg) - DB'(ray_ox_reg);
    assign dy_d = DB'(ray_ey_reg) - DB'(ray_oy_reg);
    assign wx_d = DB'(bx) - DB'(ax);
    assign wy_d = DB'(by) - DB'(ay);
    assign py_d = DB'(ray_oy_reg) - DB'(ay);
    assign px_d = DB'(ax) - DB'(ray_ox_reg);

    // sign bit of the serial operand carries negative weight
    assign sign_step = step_reg == SB'(DB - 1);
    assign den_add = pp(sr_dx_reg[0], sign_step, mc_wy_reg)
                   + pp(sr_dy_reg[0], !sign_step, mc_wx_reg);
    assign n2_add  = pp(sr_dx_reg[0], sign_step, mc_py_reg)
                   + pp(sr_dy_reg[0], sign_step, mc_px_reg);
    assign n1_add  = pp(sr_wx_reg[0], sign_step, mc_py_reg)
                   + pp(sr_wy_reg[0], sign_step, mc_px_reg);

    assign den_neg = den_reg[AB-1];
    assign den_a   = den_neg ? -den_reg : den_reg;
    assign n1_a    = den_neg ? -n1_reg : n1_reg;
    assign n2_a    = den_neg ? -n2_reg : n2_reg;
    assign wall_ok = (den_reg != '0) && !n1_a[AB-1] && (n1_a < den_a)
                   && !n2_a[AB-1] && (n2_a < den_a);
    assign div_start = (state_reg == S_CHECK) && wall_ok;

    rsnh_serial_div #(
        .WIDTH    (AB),
        .QUO_BITS (FB)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .numer    (n1_a),
        .denom    (den_a),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign out_free = !result_valid_reg || result_ready;
    assign hit      = best_reg != rsnh_pkg::FRAC_ONE;
    assign crash    = hit && (best_reg < {1'b0, threshold_reg});
    assign sum_x    = PB'(ray_ox_reg) + (px_reg >>> FB);
    assign sum_y    = PB'(ray_oy_reg) + (py_reg >>> FB);

    always_comb
    begin
        state_next = state_reg;
        best_next  = best_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    if (item.func == rsnh_pkg::FUNC_RAY)
                    begin
                        best_next = rsnh_pkg::FRAC_ONE;
                    end
                    else
                    begin
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                if (sign_step)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                state_next = wall_ok ? S_DIV : S_FINISH;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_FINISH;
                    if ({1'b0, div_quo} < best_reg)
                    begin
                        best_next = {1'b0, div_quo};
                    end
                end
            end
            S_FINISH:
            begin
                if (!last_reg)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = hit ? S_SCALE : S_EMIT;
                end
            end
            S_SCALE:
            begin
                if (step_reg == SB'(FB - 1))
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                    best_next  = rsnh_pkg::FRAC_ONE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            step_reg         <= '0;
            best_reg         <= rsnh_pkg::FRAC_ONE;
            alive_reg        <= 1'b1;
            threshold_reg    <= rsnh_pkg::CRASH_RESET;
            ray_ox_reg       <= '0;
            ray_oy_reg       <= '0;
            ray_ex_reg       <= '0;
            ray_ey_reg       <= '0;
            last_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            best_reg  <= best_next;
            if (threshold_we)
            begin
                threshold_reg <= threshold_data;
            end
            if (state_reg == S_EMIT && out_free)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    step_reg <= '0;
                    if (item_valid && item.func == rsnh_pkg::FUNC_RAY)
                    begin
                        ray_ox_reg <= ax;
                        ray_oy_reg <= ay;
                        ray_ex_reg <= bx;
                        ray_ey_reg <= by;
                    end
                    last_reg <= item.last_wall;
                end
                S_MUL, S_SCALE:
                begin
                    step_reg <= step_reg + SB'(1);
                end
                S_FINISH:
                begin
                    step_reg <= '0;
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        alive_reg <= alive_reg && !crash;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                sr_dx_reg <= dx_d;
                sr_dy_reg <= dy_d;
                sr_wx_reg <= wx_d;
                sr_wy_reg <= wy_d;
                mc_wy_reg <= AB'(wy_d);
                mc_wx_reg <= AB'(wx_d);
                mc_py_reg <= AB'(py_d);
                mc_px_reg <= AB'(px_d);
                den_reg   <= '0;
                n1_reg    <= '0;
                n2_reg    <= '0;
            end
            S_MUL:
            begin
                den_reg   <= den_reg + den_add;
                n1_reg    <= n1_reg + n1_add;
                n2_reg    <= n2_reg + n2_add;
                sr_dx_reg <= sr_dx_reg >> 1;
                sr_dy_reg <= sr_dy_reg >> 1;
                sr_wx_reg <= sr_wx_reg >> 1;
                sr_wy_reg <= sr_wy_reg >> 1;
                mc_wy_reg <= mc_wy_reg <<< 1;
                mc_wx_reg <= mc_wx_reg <<< 1;
                mc_py_reg <= mc_py_reg <<< 1;
                mc_px_reg <= mc_px_reg <<< 1;
            end
            S_FINISH:
            begin
                sr_frac_reg <= best_reg[FB-1:0];
                mx_reg      <= PB'(dx_d);
                my_reg      <= PB'(dy_d);
                px_reg      <= '0;
                py_reg      <= '0;
            end
            S_SCALE:
            begin
                if (sr_frac_reg[0])
                begin
                    px_reg <= px_reg + mx_reg;
                    py_reg <= py_reg + my_reg;
                end
                sr_frac_reg <= sr_frac_reg >> 1;
                mx_reg      <= mx_reg <<< 1;
                my_reg      <= my_reg <<< 1;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    result_reg.hit              <= hit;
                    result_reg.hit_x            <= hit ? sum_x[CB-1:0] : ray_ex_reg;
                    result_reg.hit_y            <= hit ? sum_y[CB-1:0] : ray_ey_reg;
                    result_reg.nearest_fraction <= best_reg;
                    result_reg.crash            <= crash;
                    result_reg.alive            <= alive_reg && !crash;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign item_ready   = state_reg == S_IDLE;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_hit_matches_fraction: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.hit == (result.nearest_fraction != rsnh_pkg::FRAC_ONE)))
        else $error("hit flag disagrees with nearest fraction");

    a_crash_kills: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.crash |-> !result.alive)
        else $error("crash reported while still alive");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV)
        else $error("divider finished outside divide state");

    a_scale_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCALE |-> best_reg != rsnh_pkg::FRAC_ONE)
        else $error("clip multiply without a hit");

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 80;
    localparam int HOLD_CYCLES    = 400;

    logic                           clk;
    logic                           rst_n;
    logic                           item_valid;
    logic                           item_ready;
    rsnh_pkg::item_t                item;
    logic                           result_valid;
    logic                           result_ready;
    rsnh_pkg::result_t              result;
    logic                           threshold_we;
    logic [rsnh_pkg::FRAC_BITS-1:0] threshold_data;

    // predicted block state
    longint                         ray_ox, ray_oy, ray_ex, ray_ey;
    longint                         best_frac;
    logic                           alive_now;
    logic [rsnh_pkg::FRAC_BITS-1:0] threshold_now;

    rsnh_pkg::result_t              expected_hits[$];
    int                             fail_count;
    int                             items_sent;
    int                             send_gap_pct;
    int                             recv_gap_pct;
    bit                             hold_off_req;
    int                             quiet_cycles;

    ray_segment_nearest_hit_core uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_ready     (item_ready),
        .item           (item),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .result         (result),
        .threshold_we   (threshold_we),
        .threshold_data (threshold_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int srand(input int m);
        return int'($urandom_range(0, 2 * m)) - m;
    endfunction

    function automatic void predict_nearest_hit(input rsnh_pkg::item_t it);
        longint            ax, ay, bx, by, dx, dy, wx, wy, px, py, den, n1, n2, q, hx, hy;
        rsnh_pkg::result_t r;
        ax = longint'(it.point_a_x);
        ay = longint'(it.point_a_y);
        bx = longint'(it.point_b_x);
        by = longint'(it.point_b_y);
        if (it.func == rsnh_pkg::FUNC_RAY)
        begin
            ray_ox = ax;
            ray_oy = ay;
            ray_ex = bx;
            ray_ey = by;
            best_frac = longint'(rsnh_pkg::FRAC_ONE);
            return;
        end
        dx = ray_ex - ray_ox;
        dy = ray_ey - ray_oy;
        wx = bx - ax;
        wy = by - ay;
        py = ray_oy - ay;
        px = ax - ray_ox;
        den = wy * dx - wx * dy;
        n1 = py * wx + px * wy;
        n2 = py * dx + px * dy;
        if (den != 0)
        begin
            if (den < 0)
            begin
                den = -den;
                n1 = -n1;
                n2 = -n2;
            end
            if (n1 >= 0 && n1 < den && n2 >= 0 && n2 < den)
            begin
                q = (n1 <<< rsnh_pkg::FRAC_BITS) / den;
                if (q < best_frac)
                    best_frac = q;
            end
        end
        if (!it.last_wall)
            return;
        r.hit = best_frac < longint'(rsnh_pkg::FRAC_ONE);
        if (r.hit)
        begin
            hx = ray_ox + ((dx * best_frac) >>> rsnh_pkg::FRAC_BITS);
            hy = ray_oy + ((dy * best_frac) >>> rsnh_pkg::FRAC_BITS);
        end
        else
        begin
            hx = ray_ex;
            hy = ray_ey;
        end
        r.crash = r.hit && (best_frac < longint'(threshold_now));
        if (r.crash)
            alive_now = 1'b0;
        r.hit_x = hx[rsnh_pkg::COORD_BITS-1:0];
        r.hit_y = hy[rsnh_pkg::COORD_BITS-1:0];
        r.nearest_fraction = best_frac[rsnh_pkg::BEST_BITS-1:0];
        r.alive = alive_now;
        expected_hits = {expected_hits, r};
        best_frac = longint'(rsnh_pkg::FRAC_ONE);
    endfunction

    // called at a rising edge; returns at the edge of the transfer
    task automatic send_item(input logic f, input int ax, input int ay, input int bx,
                             input int by, input logic lw);
        rsnh_pkg::item_t it;
        it.func      = f;
        it.point_a_x = ax[rsnh_pkg::COORD_BITS-1:0];
        it.point_a_y = ay[rsnh_pkg::COORD_BITS-1:0];
        it.point_b_x = bx[rsnh_pkg::COORD_BITS-1:0];
        it.point_b_y = by[rsnh_pkg::COORD_BITS-1:0];
        it.last_wall = lw;
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do
            @(posedge clk);
        while (item_ready !== 1'b1);
        predict_nearest_hit(it);
        items_sent++;
    endtask

    task automatic send_ray(input int ax, input int ay, input int bx, input int by);
        send_item(rsnh_pkg::FUNC_RAY, ax, ay, bx, by, 1'b0);
    endtask

    task automatic send_wall(input int ax, input int ay, input int bx, input int by,
                             input logic lw);
        send_item(rsnh_pkg::FUNC_WALL, ax, ay, bx, by, lw);
    endtask

    // vertical wall across the x axis
    task automatic send_post(input int x, input logic lw);
        send_wall(x, -160, x, 160, lw);
    endtask

    task automatic drain_block();
        item_valid <= 1'b0;
        while (expected_hits.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [rsnh_pkg::FRAC_BITS-1:0] v);
        threshold_we   <= 1'b1;
        threshold_data <= v;
        @(posedge clk);
        threshold_we  <= 1'b0;
        threshold_now = v;
    endtask

    task automatic send_random_ray();
        if ($urandom_range(0, 99) < 80)
            send_ray(srand(8000), srand(8000), srand(8000), srand(8000));
        else
            send_ray(int'($urandom), int'($urandom), int'($urandom), int'($urandom));
    endtask

    task automatic send_random_wall(input logic lw);
        int sel, t, k, cx, cy, vx, vy, ax, ay;
        sel = $urandom_range(0, 99);
        ax = srand(8000);
        ay = srand(8000);
        if (sel < 60)
        begin
            // wall crossing the ray somewhere along its length
            t  = $urandom_range(0, 65535);
            cx = int'(ray_ox + (((ray_ex - ray_ox) * t) >>> rsnh_pkg::FRAC_BITS));
            cy = int'(ray_oy + (((ray_ey - ray_oy) * t) >>> rsnh_pkg::FRAC_BITS));
            vx = srand(4000);
            vy = srand(4000);
            k  = $urandom_range(1, 3);
            send_wall(cx + vx, cy + vy, cx - k * vx, cy - k * vy, lw);
        end
        else if (sel < 70)
            send_wall(ax, ay, ax + int'((ray_ex - ray_ox) / 2),
                      ay + int'((ray_ey - ray_oy) / 2), lw);
        else if (sel < 75)
            send_wall(ax, ay, ax, ay, lw);
        else
            send_wall(int'($urandom), int'($urandom), int'($urandom), int'($urandom), lw);
    endtask

    task automatic test_directed();
        send_post(800, 1'b1);                 // ray still zero after reset
        send_item(rsnh_pkg::FUNC_RAY, 0, 0, 1600, 0, 1'b1);
        send_post(800, 1'b1);
        send_wall(0, 160, 1600, 160, 1'b0);   // parallel
        send_wall(800, 0, 800, 0, 1'b0);      // zero length
        send_post(400, 1'b0);
        send_post(400, 1'b0);                 // tie
        send_post(1200, 1'b1);
        send_wall(800, 0, 800, 320, 1'b1);    // cut at wall start
        send_wall(800, -320, 800, 0, 1'b1);   // cut at wall end
        send_post(1600, 1'b1);                // cut at ray end
        send_post(1599, 1'b1);
        send_ray(-32768, -32768, 32767, 32767);
        send_wall(-32768, 32767, 32767, -32768, 1'b1);
        send_ray(32767, -32768, -32768, 32767);
        send_wall(-32768, -32768, 32767, 32767, 1'b1);
        send_ray(1600, 1600, -1600, -1600);
        send_wall(-1000, 1000, 1000, -1000, 1'b1);
        send_ray(0, 0, 1600, 0);
        send_post(400, 1'b0);
        send_ray(0, 0, 1600, 0);              // reload drops the kept fraction
        send_post(1200, 1'b1);
        send_post(100, 1'b1);
        send_post(50, 1'b1);                  // crash
        send_post(800, 1'b1);
        send_post(0, 1'b1);
        drain_block();
    endtask

    task automatic test_threshold_edges();
        write_threshold(16'd4092);
        send_ray(0, 0, 16384, 0);
        send_post(1023, 1'b1);                // fraction equals threshold
        send_post(1022, 1'b1);
        drain_block();
    endtask

    task automatic test_random(input logic [rsnh_pkg::FRAC_BITS-1:0] thr, input int n);
        int target, kind, walls, i;
        write_threshold(thr);
        target = items_sent + n;
        while (items_sent < target)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 75)
            begin
                send_random_ray();
                walls = $urandom_range(1, 5);
                for (i = 0; i < walls; i++)
                    send_random_wall(i == walls - 1);
            end
            else if (kind < 85)
            begin
                walls = $urandom_range(1, 3);
                for (i = 0; i < walls; i++)
                    send_random_wall(i == walls - 1);
            end
            else if (kind < 92)
            begin
                send_random_ray();
                walls = $urandom_range(1, 3);
                for (i = 0; i < walls; i++)
                    send_random_wall(1'b0);
            end
            else
                send_item(1'($urandom_range(0, 1)), int'($urandom), int'($urandom),
                          int'($urandom), int'($urandom), 1'($urandom_range(0, 1)));
        end
        drain_block();
    endtask

    task automatic test_backpressure();
        int i;
        write_threshold(16'($urandom));
        send_ray(srand(8000), srand(8000), srand(8000), srand(8000));
        hold_off_req = 1'b1;
        for (i = 0; i < 12; i++)
            send_random_wall(1'b1);
        drain_block();
    endtask

    // receiver
    initial
    begin
        result_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                result_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end
            result_ready <= ($urandom_range(0, 99) >= recv_gap_pct);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        rsnh_pkg::result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_hits.size() == 0)
            begin
                $error("result transfer with nothing expected");
                fail_count++;
            end
            else
            begin
                want = expected_hits.pop_front();
                if (result.hit !== want.hit)
                begin
                    $error("hit: expected %0d, got %0d", want.hit, result.hit);
                    fail_count++;
                end
                if (result.hit_x !== want.hit_x)
                begin
                    $error("hit_x: expected %0d, got %0d", want.hit_x, result.hit_x);
                    fail_count++;
                end
                if (result.hit_y !== want.hit_y)
                begin
                    $error("hit_y: expected %0d, got %0d", want.hit_y, result.hit_y);
                    fail_count++;
                end
                if (result.nearest_fraction !== want.nearest_fraction)
                begin
                    $error("nearest_fraction: expected %0d, got %0d",
                           want.nearest_fraction, result.nearest_fraction);
                    fail_count++;
                end
                if (result.crash !== want.crash)
                begin
                    $error("crash: expected %0d, got %0d", want.crash, result.crash);
                    fail_count++;
                end
                if (result.alive !== want.alive)
                begin
                    $error("alive: expected %0d, got %0d", want.alive, result.alive);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("tb_top failed");
        $finish;
    end

    initial
    begin
        item_valid     = 1'b0;
        item           = '0;
        threshold_we   = 1'b0;
        threshold_data = '0;
        rst_n          = 1'b0;
        fail_count     = 0;
        items_sent     = 0;
        hold_off_req   = 1'b0;
        send_gap_pct   = 20;
        recv_gap_pct   = 80;
        ray_ox         = 0;
        ray_oy         = 0;
        ray_ex         = 0;
        ray_ey         = 0;
        best_frac      = longint'(rsnh_pkg::FRAC_ONE);
        alive_now      = 1'b1;
        threshold_now  = rsnh_pkg::CRASH_RESET;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_threshold_edges();
        test_random(16'd0, 200);
        send_gap_pct = 80;
        recv_gap_pct = 20;
        test_random(16'hFFFF, 200);
        test_backpressure();
        send_gap_pct = 0;
        recv_gap_pct = 0;
        test_random(rsnh_pkg::CRASH_RESET, 200);

        if (fail_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/rsnh_pkg.sv
sv/rsnh_serial_div.sv
sv/ray_segment_nearest_hit_core.sv
bench/tb_top.sv
